/* hw/rtl/skt_pkg.sv */
// Shared types and constants for the sorted key table.
package skt_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int KEY_BITS_DEF    = 64;
    localparam int VALUE_BITS_DEF  = 32;

    localparam int CMD_W    = 2;
    localparam int KEY_W    = 64;
    localparam int NAME_W   = 64;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 8;
    localparam int COUNT_W  = 9;

    localparam int S_TDATA_W = 176;
    localparam int M_TDATA_W = 24;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_DELETE = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_RANGE     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_SCAN,
        S_INS_PUT,
        S_SRCH_ISSUE,
        S_SRCH_CMP,
        S_DEL_SHIFT,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [KEY_W-1:0]   entry_key;
        logic [NAME_W-1:0]  entry_name;
        logic [VALUE_W-1:0] entry_value;
        logic [POS_W-1:0]   position;
        logic               position_absent;
    } req_t;

    typedef struct packed {
        status_t              status;
        logic [INDEX_W-1:0]   found_index;
        logic [COUNT_W-1:0]   count_now;
    } resp_t;

endpackage

/* hw/rtl/sorted_key_table.sv */
// Top level of the sorted key table: stream ports, sequencer, entry RAM and output register.
//
// Entries are kept sorted by unsigned key in one RAM that moves one entry per
// cycle through its single write port. One command is worked on at a time.
// Insert scans down from the top entry, shifting every entry whose key is not
// less than the new key up by one; delete shifts the entries above the position
// down; search alternates issuing a probe and comparing its key, halving the
// range each time. Entry contents are not cleared at reset; only entries below
// the count are ever used. A result may wait in the output register while the
// next command is already accepted.
module sorted_key_table #(
    parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = skt_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS  = skt_pkg::VALUE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // entry_key, entry_name, entry_value, position, position_absent, zero pad
    input  logic [skt_pkg::S_TDATA_W-1:0]   s_tdata,
    // cmd
    input  logic [skt_pkg::CMD_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status, found_index, count_now, zero pad
    output logic [skt_pkg::M_TDATA_W-1:0]   m_tdata
);

    skt_pkg::req_t  req;
    skt_pkg::resp_t resp;
    skt_pkg::resp_t out_resp;
    logic           resp_valid;
    logic           resp_ready;

    assign req.cmd             = s_tuser;
    assign req.entry_key       = s_tdata[63:0];
    assign req.entry_name      = s_tdata[127:64];
    assign req.entry_value     = s_tdata[159:128];
    assign req.position        = s_tdata[167:160];
    assign req.position_absent = s_tdata[168];

    skt_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .req        (req),
        .resp_valid (resp_valid),
        .resp_ready (resp_ready),
        .resp       (resp)
    );

    skt_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .resp_valid (resp_valid),
        .resp_ready (resp_ready),
        .resp       (resp),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_resp   (out_resp)
    );

    assign m_tdata = {5'd0, out_resp.count_now, out_resp.found_index, out_resp.status};

endmodule

/* hw/rtl/skt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module skt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/skt_ctrl.sv */
// Command sequencer: insert scan/shift, binary search and delete shift over the entry RAM.
module skt_ctrl #(
    parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = skt_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS  = skt_pkg::VALUE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  skt_pkg::req_t req,
    output logic          resp_valid,
    input  logic          resp_ready,
    output skt_pkg::resp_t resp
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = KEY_BITS + skt_pkg::NAME_W + VALUE_BITS;
    localparam int PW = (CW > skt_pkg::POS_W) ? CW : skt_pkg::POS_W;
    localparam int IW = (AW > skt_pkg::INDEX_W) ? AW : skt_pkg::INDEX_W;
    localparam int NW = (CW > skt_pkg::COUNT_W) ? CW : skt_pkg::COUNT_W;

    skt_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    lo_reg, lo_next;
    logic [CW-1:0]    r_reg, r_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [skt_pkg::NAME_W-1:0] name_reg, name_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    skt_pkg::status_t status_reg, status_next;
    logic [AW-1:0]    found_reg, found_next;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [EW-1:0]    wr_data;
    logic [AW-1:0]    rd_addr;
    logic [EW-1:0]    rd_data;

    logic             accept;
    logic             is_full;
    logic             is_empty;
    logic [PW-1:0]    pos_ext;
    logic             pos_in_range;
    logic             pos_has_next;
    logic [KEY_BITS-1:0] rd_key;
    logic             rd_key_ge;
    logic             rd_key_lt;
    logic             rd_key_gt;
    logic             srch_open;
    logic [CW:0]      mid_sum;
    logic [AW-1:0]    mid;
    logic             del_more;
    logic [EW-1:0]    new_entry;
    logic [IW-1:0]    found_wide;
    logic [NW-1:0]    count_wide;

    skt_ram #(
        .WIDTH(EW),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req_ready    = (state_reg == skt_pkg::S_IDLE);
    assign accept       = req_valid && req_ready;
    assign is_full      = (count_reg == CW'(TABLE_DEPTH));
    assign is_empty     = (count_reg == '0);
    assign pos_ext      = PW'(req.position);
    assign pos_in_range = (pos_ext < PW'(count_reg));
    assign pos_has_next = ((pos_ext + PW'(1)) < PW'(count_reg));
    assign rd_key       = rd_data[KEY_BITS-1:0];
    assign rd_key_ge    = (rd_key >= key_reg);
    assign rd_key_lt    = (rd_key < key_reg);
    assign rd_key_gt    = (rd_key > key_reg);
    assign srch_open    = (lo_reg < r_reg);
    assign mid_sum      = (CW+1)'(lo_reg) + (CW+1)'(r_reg) - (CW+1)'(1);
    assign mid          = AW'(mid_sum >> 1);
    assign del_more     = (((CW+1)'(idx_reg) + (CW+1)'(1)) < (CW+1)'(count_reg));
    assign new_entry    = {value_reg, name_reg, key_reg};
    assign found_wide   = IW'(found_reg);
    assign count_wide   = NW'(count_reg);

    assign resp_valid       = (state_reg == skt_pkg::S_RESP);
    assign resp.status      = status_reg;
    assign resp.found_index = found_wide[skt_pkg::INDEX_W-1:0];
    assign resp.count_now   = count_wide[skt_pkg::COUNT_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            skt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (skt_pkg::cmd_t'(req.cmd))
                        skt_pkg::CMD_INSERT:
                        begin
                            if (is_full)
                                state_next = skt_pkg::S_RESP;
                            else if (is_empty)
                                state_next = skt_pkg::S_INS_PUT;
                            else
                                state_next = skt_pkg::S_INS_SCAN;
                        end
                        skt_pkg::CMD_SEARCH:
                            state_next = skt_pkg::S_SRCH_ISSUE;
                        skt_pkg::CMD_DELETE:
                        begin
                            if (!req.position_absent && pos_in_range && pos_has_next)
                                state_next = skt_pkg::S_DEL_SHIFT;
                            else
                                state_next = skt_pkg::S_RESP;
                        end
                        default:
                            state_next = skt_pkg::S_RESP;
                    endcase
                end
            end
            skt_pkg::S_INS_SCAN:
            begin
                if (!rd_key_ge)
                    state_next = skt_pkg::S_RESP;
                else if (idx_reg == '0)
                    state_next = skt_pkg::S_INS_PUT;
            end
            skt_pkg::S_INS_PUT:
                state_next = skt_pkg::S_RESP;
            skt_pkg::S_SRCH_ISSUE:
                state_next = srch_open ? skt_pkg::S_SRCH_CMP : skt_pkg::S_RESP;
            skt_pkg::S_SRCH_CMP:
                state_next = (rd_key_lt || rd_key_gt) ? skt_pkg::S_SRCH_ISSUE
                                                      : skt_pkg::S_RESP;
            skt_pkg::S_DEL_SHIFT:
            begin
                if (!del_more)
                    state_next = skt_pkg::S_RESP;
            end
            skt_pkg::S_RESP:
            begin
                if (resp_ready)
                    state_next = skt_pkg::S_IDLE;
            end
            default:
                state_next = skt_pkg::S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        lo_next     = lo_reg;
        r_next      = r_reg;
        key_next    = key_reg;
        name_next   = name_reg;
        value_next  = value_reg;
        status_next = status_reg;
        found_next  = found_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg + AW'(1);
        wr_data     = rd_data;
        rd_addr     = idx_reg;
        unique case (state_reg)
            skt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    key_next    = KEY_BITS'(req.entry_key);
                    name_next   = req.entry_name;
                    value_next  = VALUE_BITS'(req.entry_value);
                    lo_next     = '0;
                    r_next      = count_reg;
                    status_next = skt_pkg::ST_NOT_FOUND;
                    found_next  = '0;
                    unique case (skt_pkg::cmd_t'(req.cmd))
                        skt_pkg::CMD_INSERT:
                        begin
                            rd_addr  = AW'(count_reg - CW'(1));
                            idx_next = AW'(count_reg - CW'(1));
                            if (is_full)
                                status_next = skt_pkg::ST_FULL;
                            else if (is_empty)
                                idx_next = '0;
                        end
                        skt_pkg::CMD_SEARCH:
                        begin
                            rd_addr = '0;
                        end
                        skt_pkg::CMD_DELETE:
                        begin
                            rd_addr  = AW'(pos_ext + PW'(1));
                            idx_next = AW'(pos_ext + PW'(1));
                            if (req.position_absent)
                                status_next = skt_pkg::ST_NOT_FOUND;
                            else if (!pos_in_range)
                                status_next = skt_pkg::ST_RANGE;
                            else
                            begin
                                status_next = skt_pkg::ST_OK;
                                found_next  = AW'(pos_ext);
                                if (!pos_has_next)
                                    count_next = count_reg - CW'(1);
                            end
                        end
                        default:
                        begin
                            rd_addr = '0;
                        end
                    endcase
                end
            end
            skt_pkg::S_INS_SCAN:
            begin
                wr_en = 1'b1;
                if (rd_key_ge)
                begin
                    if (idx_reg != '0)
                    begin
                        rd_addr  = idx_reg - AW'(1);
                        idx_next = idx_reg - AW'(1);
                    end
                end
                else
                begin
                    wr_data     = new_entry;
                    found_next  = idx_reg + AW'(1);
                    status_next = skt_pkg::ST_OK;
                    count_next  = count_reg + CW'(1);
                end
            end
            skt_pkg::S_INS_PUT:
            begin
                wr_en       = 1'b1;
                wr_addr     = idx_reg;
                wr_data     = new_entry;
                found_next  = idx_reg;
                status_next = skt_pkg::ST_OK;
                count_next  = count_reg + CW'(1);
            end
            skt_pkg::S_SRCH_ISSUE:
            begin
                rd_addr  = mid;
                idx_next = mid;
            end
            skt_pkg::S_SRCH_CMP:
            begin
                if (rd_key_lt)
                    lo_next = CW'(idx_reg) + CW'(1);
                else if (rd_key_gt)
                    r_next = CW'(idx_reg);
                else
                begin
                    status_next = skt_pkg::ST_OK;
                    found_next  = idx_reg;
                end
            end
            skt_pkg::S_DEL_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg - AW'(1);
                if (del_more)
                begin
                    rd_addr  = idx_reg + AW'(1);
                    idx_next = idx_reg + AW'(1);
                end
                else
                    count_next = count_reg - CW'(1);
            end
            skt_pkg::S_RESP:
            begin
                rd_addr = idx_reg;
            end
            default:
            begin
                rd_addr = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skt_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        lo_reg     <= lo_next;
        r_reg      <= r_next;
        key_reg    <= key_next;
        name_reg   <= name_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        found_reg  <= found_next;
    end

endmodule

/* hw/rtl/skt_out.sv */
// Output register stage holding one result transaction.
module skt_out (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           resp_valid,
    output logic           resp_ready,
    input  skt_pkg::resp_t resp,
    output logic           out_valid,
    input  logic           out_ready,
    output skt_pkg::resp_t out_resp
);

    logic           valid_reg, valid_next;
    skt_pkg::resp_t data_reg, data_next;

    assign resp_ready = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_resp   = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (resp_ready)
        begin
            valid_next = resp_valid;
            if (resp_valid)
                data_next = resp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

/* hw/rtl/skt_check.sv */
// Port-level assertions for the sorted key table, bound to the top level.
module skt_check #(
    parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [skt_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int CNT_W = (TABLE_DEPTH > 511) ? 32 : skt_pkg::COUNT_W;

    logic [skt_pkg::STATUS_W-1:0] status;
    logic [skt_pkg::INDEX_W-1:0]  found_index;
    logic [skt_pkg::COUNT_W-1:0]  count_now;
    logic [CNT_W-1:0]             depth_masked;

    assign status       = m_tdata[1:0];
    assign found_index  = m_tdata[9:2];
    assign count_now    = m_tdata[18:10];
    assign depth_masked = CNT_W'(TABLE_DEPTH % 512);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction taken while one is in work");

    a_index_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (status != skt_pkg::ST_OK) |-> found_index == '0)
        else $error("nonzero index on failed command");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (status == skt_pkg::ST_FULL) |-> CNT_W'(count_now) == depth_masked)
        else $error("table full reported below depth");

endmodule

bind sorted_key_table skt_check #(
    .TABLE_DEPTH(TABLE_DEPTH)
) u_skt_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
